[hw/rtl/four_level_page_table_walker_macros.svh]
// ----------------------------------------------------------------------------
// Four-level page table walker assertion macros
// Shared helpers for the concurrent checks on the walker's ports.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH

// Same-cycle implication, sampled on the walker clock and held off in reset.
`define FLPTW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("flptw check failed");

// Next-cycle implication, sampled on the walker clock and held off in reset.
`define FLPTW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("flptw check failed");

`endif

[hw/rtl/flptw_pkg.sv]
// ----------------------------------------------------------------------------
// Four-level page table walker package
// Widths, address masks, result codes and the result record.
// ----------------------------------------------------------------------------
package flptw_pkg;

    localparam int PHYS_ADDR_BITS = 36;
    localparam int VA_BITS        = 48;
    localparam int ENTRY_BITS     = 64;
    localparam int FETCH_BITS     = 36;
    localparam int PHYS_OUT_BITS  = 52;
    localparam int INDEX_BITS     = 9;

    // Entry masks for table bases, 2 MiB bases and 1 GiB bases.
    localparam logic [PHYS_OUT_BITS-1:0] TABLE_MASK =
        PHYS_OUT_BITS'(((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~64'hFFF);
    localparam logic [PHYS_OUT_BITS-1:0] MID_MASK =
        PHYS_OUT_BITS'(((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~64'h1F_FFFF);
    localparam logic [PHYS_OUT_BITS-1:0] GIG_MASK = 52'hF_FFFF_C000_0000;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    typedef enum logic {
        OP_START = 1'b0,
        OP_ENTRY = 1'b1
    } t_operation;

    typedef enum logic {
        KIND_FETCH = 1'b0,
        KIND_DONE  = 1'b1
    } t_result_kind;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NOT_PRESENT = 2'd1,
        STATUS_PROTOCOL    = 2'd2
    } t_status;

    typedef struct packed {
        t_result_kind             kind;
        logic [FETCH_BITS-1:0]    fetch_address;
        logic [PHYS_OUT_BITS-1:0] physical_address;
        t_status                  status;
    } t_result;

    localparam logic [0:0] REG_ROOT = 1'b0;

endpackage

[hw/rtl/four_level_page_table_walker.sv]
// ----------------------------------------------------------------------------
// Four-level page table walker
// An accepted request's result is registered in the output entry, or in the skid entry while the output stalls.
// One request per cycle while the skid entry is empty; each step is masking and one 36-bit add.
// A two-entry output buffer lets requests flow while the consumer stalls.
// Reset (synchronous, active low) clears the root, the walk level, the
// saved address and the valid flags of both output buffer entries.
// ----------------------------------------------------------------------------
module four_level_page_table_walker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [3:0]                            paddr,
    input  logic [63:0]                           pwdata,
    output logic [63:0]                           prdata,
    output logic                                  pready,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_operation,
    input  logic [flptw_pkg::VA_BITS-1:0]         i_virtual_address,
    input  logic [flptw_pkg::ENTRY_BITS-1:0]      i_entry_data,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_result_kind,
    output logic [flptw_pkg::FETCH_BITS-1:0]      o_fetch_address,
    output logic [flptw_pkg::PHYS_OUT_BITS-1:0]   o_physical_address,
    output logic [1:0]                            o_status
);

    typedef enum logic [2:0] {
        LVL_IDLE = 3'd0,
        LVL_PML4 = 3'd1,
        LVL_PDPT = 3'd2,
        LVL_PD   = 3'd3,
        LVL_PT   = 3'd4
    } t_level;

    logic [flptw_pkg::FETCH_BITS-1:0] r_root;
    t_level                           r_level, n_level;
    logic [flptw_pkg::VA_BITS-1:0]    r_saved, n_saved;
    flptw_pkg::t_result               r_out, r_skid, n_result;
    logic                             r_out_valid, r_skid_valid;

    logic                                 w_accept;
    logic                                 w_out_fire;
    logic                                 w_cfg_write;
    logic [flptw_pkg::INDEX_BITS-1:0]     w_index;
    logic [flptw_pkg::PHYS_OUT_BITS-1:0]  w_tbl_base;
    logic [flptw_pkg::FETCH_BITS-1:0]     w_tbl_fetch;
    logic [flptw_pkg::FETCH_BITS-1:0]     w_root_fetch;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign prdata      = (paddr[3] == flptw_pkg::REG_ROOT)
                       ? {{(64 - flptw_pkg::FETCH_BITS){1'b0}}, r_root} : 64'd0;

    assign o_in_ready = !r_skid_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_fire = r_out_valid && i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_result_kind      = r_out.kind;
    assign o_fetch_address    = r_out.fetch_address;
    assign o_physical_address = r_out.physical_address;
    assign o_status           = r_out.status;

    // Index of the next table, taken from the saved address at the new level.
    always_comb begin
        unique case (r_level)
            LVL_PML4: w_index = r_saved[38:30];
            LVL_PDPT: w_index = r_saved[29:21];
            default:  w_index = r_saved[20:12];
        endcase
    end

    assign w_tbl_base   = i_entry_data[flptw_pkg::PHYS_OUT_BITS-1:0] & flptw_pkg::TABLE_MASK;
    assign w_tbl_fetch  = w_tbl_base[flptw_pkg::FETCH_BITS-1:0]
                        + {{(flptw_pkg::FETCH_BITS - flptw_pkg::INDEX_BITS - 3){1'b0}},
                           w_index, 3'b000};
    assign w_root_fetch = {r_root[flptw_pkg::FETCH_BITS-1:4], 4'b0000}
                        + {{(flptw_pkg::FETCH_BITS - flptw_pkg::INDEX_BITS - 3){1'b0}},
                           i_virtual_address[47:39], 3'b000};

    always_comb begin
        n_level  = r_level;
        n_saved  = r_saved;
        n_result = '{kind: flptw_pkg::KIND_DONE, fetch_address: '0,
                     physical_address: '0, status: flptw_pkg::STATUS_OK};
        if (i_operation == flptw_pkg::OP_START) begin
            n_saved                = i_virtual_address;
            n_level                = LVL_PML4;
            n_result.kind          = flptw_pkg::KIND_FETCH;
            n_result.fetch_address = w_root_fetch;
        end else if (r_level == LVL_IDLE || r_level > LVL_PT) begin
            n_level         = LVL_IDLE;
            n_result.status = flptw_pkg::STATUS_PROTOCOL;
        end else if (!i_entry_data[flptw_pkg::PRESENT_BIT]) begin
            n_level         = LVL_IDLE;
            n_result.status = flptw_pkg::STATUS_NOT_PRESENT;
        end else begin
            unique case (r_level)
                LVL_PML4: begin
                    n_level                = LVL_PDPT;
                    n_result.kind          = flptw_pkg::KIND_FETCH;
                    n_result.fetch_address = w_tbl_fetch;
                end
                LVL_PDPT: begin
                    if (i_entry_data[flptw_pkg::LARGE_BIT]) begin
                        n_level                   = LVL_IDLE;
                        n_result.physical_address =
                            (i_entry_data[flptw_pkg::PHYS_OUT_BITS-1:0] & flptw_pkg::GIG_MASK)
                            | {22'd0, r_saved[29:0]};
                    end else begin
                        n_level                = LVL_PD;
                        n_result.kind          = flptw_pkg::KIND_FETCH;
                        n_result.fetch_address = w_tbl_fetch;
                    end
                end
                LVL_PD: begin
                    if (i_entry_data[flptw_pkg::LARGE_BIT]) begin
                        n_level                   = LVL_IDLE;
                        n_result.physical_address =
                            (i_entry_data[flptw_pkg::PHYS_OUT_BITS-1:0] & flptw_pkg::MID_MASK)
                            | {31'd0, r_saved[20:0]};
                    end else begin
                        n_level                = LVL_PT;
                        n_result.kind          = flptw_pkg::KIND_FETCH;
                        n_result.fetch_address = w_tbl_fetch;
                    end
                end
                default: begin
                    n_level = LVL_IDLE;
                    // An all-zero page base counts as a missing page.
                    if (w_tbl_base == '0) begin
                        n_result.status = flptw_pkg::STATUS_NOT_PRESENT;
                    end else begin
                        n_result.physical_address = w_tbl_base | {40'd0, r_saved[11:0]};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root       <= '0;
            r_level      <= LVL_IDLE;
            r_saved      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_cfg_write && paddr[3] == flptw_pkg::REG_ROOT) begin
                r_root <= pwdata[flptw_pkg::FETCH_BITS-1:0];
            end
            if (w_accept) begin
                r_level <= n_level;
                r_saved <= n_saved;
            end
            // The skid entry is only filled while the output entry stalls.
            if (w_out_fire) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else if (w_accept) begin
                    r_out <= n_result;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (w_accept) begin
                if (!r_out_valid) begin
                    r_out       <= n_result;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= n_result;
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

endmodule

[hw/rtl/flptw_checker.sv]
// ----------------------------------------------------------------------------
// Four-level page table walker checker
// Port-level checks on result consistency, bound to the walker top level.
// ----------------------------------------------------------------------------
`include "four_level_page_table_walker_macros.svh"

module flptw_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  pready,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    input  logic                                  o_result_kind,
    input  logic [flptw_pkg::FETCH_BITS-1:0]      o_fetch_address,
    input  logic [flptw_pkg::PHYS_OUT_BITS-1:0]   o_physical_address,
    input  logic [1:0]                            o_status
);

    // A fetch request never carries a status or a translated address.
    `FLPTW_ASSERT_NOW(a_fetch_clean, o_out_valid && o_result_kind == flptw_pkg::KIND_FETCH, o_status == flptw_pkg::STATUS_OK && o_physical_address == '0)

    // A finished translation never carries a fetch address.
    `FLPTW_ASSERT_NOW(a_done_no_fetch, o_out_valid && o_result_kind == flptw_pkg::KIND_DONE, o_fetch_address == '0)

    // Faults only come as finished translations with a zero address.
    `FLPTW_ASSERT_NOW(a_fault_zero, o_out_valid && o_status != flptw_pkg::STATUS_OK, o_result_kind == flptw_pkg::KIND_DONE && o_physical_address == '0 && o_status != 2'd3)

    // A stalled result stays on the port unchanged.
    `FLPTW_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_physical_address) && $stable(o_fetch_address))

    `FLPTW_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind four_level_page_table_walker flptw_checker u_flptw_checker (.*);
